/* design/crcfr_pkg.sv */
// ----------------------------------------------------------------------------
// crcfr_pkg: shared constants and CRC helper for the frame receiver
// Frame geometry, CRC-16 constants, status and register codes.
// ----------------------------------------------------------------------------
package crcfr_pkg;

   // frame geometry
   localparam int FRAME_BYTES = 32;
   localparam int PAYLOAD_MAX = 27;
   localparam int OVERHEAD    = FRAME_BYTES - PAYLOAD_MAX;
   localparam int HDR_BYTES   = 3;

   localparam int POS_W  = $clog2(FRAME_BYTES + 1);
   localparam int CNT_W  = $clog2(PAYLOAD_MAX + 1);
   localparam int ST_AW  = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

   // reflected CRC-16, shift-right form
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'd49061;

   // result status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_LEN_ERR = 2'd1;
   localparam logic [1:0] STATUS_CRC_ERR = 2'd2;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEVICE_ID = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_CODE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NACK_CODE = 2'd2;

   // register reset values
   localparam logic [7:0] DEVICE_ID_RST = 8'd0;
   localparam logic [7:0] ACK_CODE_RST  = 8'd6;
   localparam logic [7:0] NACK_CODE_RST = 8'd21;

   // one byte of CRC update, eight bit steps
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

/* design/crc16_frame_receiver_ack.sv */
// ----------------------------------------------------------------------------
// crc16_frame_receiver_ack: CRC-16 checked fixed-length frame receiver
// Collects frames byte by byte, checks length and CRC, then emits payload
// bytes of good frames and a status result with the acknowledge decision.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while req_stall is low.
// Results: the closing byte of a frame starts a drain job, which loads the output register;
// results leave one per cycle while rsp_stall is low (up to PAYLOAD_MAX + 1 per frame).
// The last byte of a frame waits (req_stall) only while the previous frame's
// results are still draining from the output queue.
// Reset (synchronous): position 0, CRC 0xFFFF, headers 0, registers to their
// defaults; the payload store is not cleared.
module crc16_frame_receiver_ack (
   input  logic        clock,
   input  logic        reset,
   // byte requests
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_resync,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_is_status,
   output logic [7:0]  rsp_frame_id,
   output logic [7:0]  rsp_frame_command,
   output logic [7:0]  rsp_frame_length,
   output logic [1:0]  rsp_status,
   output logic        rsp_send_reply,
   output logic [7:0]  rsp_reply_command,
   output logic [7:0]  rsp_reply_id,
   output logic        rsp_last,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [crcfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int POS_W = crcfr_pkg::POS_W;
   localparam int CNT_W = crcfr_pkg::CNT_W;
   localparam int ST_AW = crcfr_pkg::ST_AW;
   localparam int PMAX  = crcfr_pkg::PAYLOAD_MAX;

   // registers
   logic [7:0] device_id_ff, ack_code_ff, nack_code_ff;

   // receive state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic [7:0]       hdr_id_ff, hdr_id_in;
   logic [7:0]       hdr_cmd_ff, hdr_cmd_in;
   logic [7:0]       hdr_len_ff, hdr_len_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic [7:0]       store_ff [PMAX];

   // drain job and output queue
   logic             job_active_ff, job_active_in;
   logic [CNT_W-1:0] job_count_ff, job_count_in;
   logic [1:0]       job_status_ff, job_status_in;
   logic [7:0]       job_id_ff, job_id_in;
   logic [7:0]       job_cmd_ff, job_cmd_in;
   logic [7:0]       job_len_ff, job_len_in;
   logic [7:0]       queue_ff [PMAX];
   logic [7:0]       queue_in [PMAX];

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_payload_ff, rsp_payload_in;
   logic       rsp_is_status_ff, rsp_is_status_in;
   logic [7:0] rsp_id_ff, rsp_id_in;
   logic [7:0] rsp_cmd_ff, rsp_cmd_in;
   logic [7:0] rsp_len_ff, rsp_len_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic       rsp_reply_ff, rsp_reply_in;
   logic [7:0] rsp_rcmd_ff, rsp_rcmd_in;
   logic [7:0] rsp_rid_ff, rsp_rid_in;
   logic       rsp_last_ff, rsp_last_in;

   // per-byte decode
   logic [POS_W-1:0] pos_eff;
   logic [POS_W-1:0] st_off;
   logic [15:0]      crc_cur;
   logic             is_last;
   logic             in_go;
   logic             crc_byte;
   logic             store_wr;
   logic             len_bad;
   logic             crc_bad;
   logic             drain_go;

   // register port: always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= crcfr_pkg::DEVICE_ID_RST;
         ack_code_ff  <= crcfr_pkg::ACK_CODE_RST;
         nack_code_ff <= crcfr_pkg::NACK_CODE_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            crcfr_pkg::CSR_DEVICE_ID: device_id_ff <= csr_wdata;
            crcfr_pkg::CSR_ACK_CODE:  ack_code_ff  <= csr_wdata;
            crcfr_pkg::CSR_NACK_CODE: nack_code_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // byte position decode; a stray position counts as the first byte
   always_comb begin
      pos_eff = (req_resync || (pos_ff >= POS_W'(crcfr_pkg::FRAME_BYTES)))
                ? '0 : pos_ff;
      is_last  = (pos_eff == POS_W'(crcfr_pkg::FRAME_BYTES - 1));
      crc_cur  = (pos_eff == '0) ? crcfr_pkg::CRC_INIT : crc_ff;
      crc_byte = ((pos_eff + POS_W'(2)) < POS_W'(crcfr_pkg::FRAME_BYTES));
      st_off   = pos_eff - POS_W'(crcfr_pkg::HDR_BYTES);
      store_wr = crc_byte && (pos_eff >= POS_W'(crcfr_pkg::HDR_BYTES))
                 && (st_off < POS_W'(PMAX));
      len_bad  = (hdr_len_ff <= 8'(crcfr_pkg::OVERHEAD))
                 || (hdr_len_ff > 8'(PMAX));
      crc_bad  = ({req_rx_byte, crc_lo_ff} != crc_cur);
   end

   // the closing byte waits until the previous frame has drained
   assign req_stall = is_last && job_active_ff;
   assign in_go     = req_valid && !req_stall;

   // receive state next values
   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      hdr_id_in  = hdr_id_ff;
      hdr_cmd_in = hdr_cmd_ff;
      hdr_len_in = hdr_len_ff;
      crc_lo_in  = crc_lo_ff;
      if (in_go) begin
         if (pos_eff == POS_W'(0)) hdr_id_in  = req_rx_byte;
         if (pos_eff == POS_W'(1)) hdr_cmd_in = req_rx_byte;
         if (pos_eff == POS_W'(2)) hdr_len_in = req_rx_byte;
         if (crc_byte) begin
            crc_in = crcfr_pkg::crc16_byte(crc_cur, req_rx_byte);
         end else if (pos_eff == POS_W'(crcfr_pkg::FRAME_BYTES - 2)) begin
            crc_lo_in = req_rx_byte;
         end
         if (is_last) begin
            pos_in = '0;
            crc_in = crcfr_pkg::CRC_INIT;
         end else begin
            pos_in = pos_eff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         crc_ff     <= crcfr_pkg::CRC_INIT;
         hdr_id_ff  <= '0;
         hdr_cmd_ff <= '0;
         hdr_len_ff <= '0;
         crc_lo_ff  <= '0;
      end else begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         hdr_id_ff  <= hdr_id_in;
         hdr_cmd_ff <= hdr_cmd_in;
         hdr_len_ff <= hdr_len_in;
         crc_lo_ff  <= crc_lo_in;
      end
   end

   // payload store
   always_ff @(posedge clock) begin
      if (in_go && store_wr) begin
         store_ff[st_off[ST_AW-1:0]] <= req_rx_byte;
      end
   end

   // drain advances when the output register is free or being taken
   assign drain_go = job_active_ff && (!rsp_valid_ff || !rsp_stall);

   // job start on the closing byte, drain one result per step
   always_comb begin
      job_active_in = job_active_ff;
      job_count_in  = job_count_ff;
      job_status_in = job_status_ff;
      job_id_in     = job_id_ff;
      job_cmd_in    = job_cmd_ff;
      job_len_in    = job_len_ff;
      queue_in      = queue_ff;
      if (in_go && is_last) begin
         job_active_in = 1'b1;
         job_id_in     = hdr_id_ff;
         job_cmd_in    = hdr_cmd_ff;
         job_len_in    = hdr_len_ff;
         queue_in      = store_ff;
         job_count_in  = '0;
         if (len_bad) begin
            job_status_in = crcfr_pkg::STATUS_LEN_ERR;
         end else if (crc_bad) begin
            job_status_in = crcfr_pkg::STATUS_CRC_ERR;
         end else begin
            job_status_in = crcfr_pkg::STATUS_OK;
            job_count_in  = hdr_len_ff[CNT_W-1:0];
         end
      end else if (drain_go) begin
         if (job_count_ff != '0) begin
            job_count_in = job_count_ff - CNT_W'(1);
            for (int i = 0; i < PMAX - 1; i++) begin
               queue_in[i] = queue_ff[i + 1];
            end
         end else begin
            job_active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_active_ff <= 1'b0;
         job_count_ff  <= '0;
      end else begin
         job_active_ff <= job_active_in;
         job_count_ff  <= job_count_in;
      end
   end

   always_ff @(posedge clock) begin
      job_status_ff <= job_status_in;
      job_id_ff     <= job_id_in;
      job_cmd_ff    <= job_cmd_in;
      job_len_ff    <= job_len_in;
      queue_ff      <= queue_in;
   end

   // output register load
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_payload_in   = rsp_payload_ff;
      rsp_is_status_in = rsp_is_status_ff;
      rsp_id_in        = rsp_id_ff;
      rsp_cmd_in       = rsp_cmd_ff;
      rsp_len_in       = rsp_len_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_reply_in     = rsp_reply_ff;
      rsp_rcmd_in      = rsp_rcmd_ff;
      rsp_rid_in       = rsp_rid_ff;
      rsp_last_in      = rsp_last_ff;
      if (drain_go) begin
         rsp_valid_in = 1'b1;
         if (job_count_ff != '0) begin
            // payload byte
            rsp_payload_in   = queue_ff[0];
            rsp_is_status_in = 1'b0;
            rsp_id_in        = '0;
            rsp_cmd_in       = '0;
            rsp_len_in       = '0;
            rsp_status_in    = crcfr_pkg::STATUS_OK;
            rsp_reply_in     = 1'b0;
            rsp_rcmd_in      = '0;
            rsp_rid_in       = '0;
            rsp_last_in      = 1'b0;
         end else begin
            // frame status
            rsp_payload_in   = '0;
            rsp_is_status_in = 1'b1;
            rsp_id_in        = job_id_ff;
            rsp_cmd_in       = job_cmd_ff;
            rsp_len_in       = job_len_ff;
            rsp_status_in    = job_status_ff;
            rsp_reply_in     = (job_status_ff != crcfr_pkg::STATUS_LEN_ERR);
            rsp_rid_in       = rsp_reply_in ? device_id_ff : '0;
            rsp_last_in      = 1'b1;
            case (job_status_ff)
               crcfr_pkg::STATUS_OK:      rsp_rcmd_in = ack_code_ff;
               crcfr_pkg::STATUS_CRC_ERR: rsp_rcmd_in = nack_code_ff;
               default:                   rsp_rcmd_in = '0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff   <= rsp_payload_in;
      rsp_is_status_ff <= rsp_is_status_in;
      rsp_id_ff        <= rsp_id_in;
      rsp_cmd_ff       <= rsp_cmd_in;
      rsp_len_ff       <= rsp_len_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_reply_ff     <= rsp_reply_in;
      rsp_rcmd_ff      <= rsp_rcmd_in;
      rsp_rid_ff       <= rsp_rid_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_byte  = rsp_payload_ff;
   assign rsp_is_status     = rsp_is_status_ff;
   assign rsp_frame_id      = rsp_id_ff;
   assign rsp_frame_command = rsp_cmd_ff;
   assign rsp_frame_length  = rsp_len_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_send_reply    = rsp_reply_ff;
   assign rsp_reply_command = rsp_rcmd_ff;
   assign rsp_reply_id      = rsp_rid_ff;
   assign rsp_last          = rsp_last_ff;

   // checks
   a_stall_only_on_busy: assert property (@(posedge clock) disable iff (reset)
      !job_active_ff |-> !req_stall)
      else $error("input stalled with no pending results");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      job_active_ff |-> (job_count_ff <= CNT_W'(PMAX)))
      else $error("drain count beyond payload limit");

   a_frame_end_rewinds: assert property (@(posedge clock) disable iff (reset)
      (in_go && is_last) |=> (pos_ff == '0 && crc_ff == crcfr_pkg::CRC_INIT
                               && job_active_ff))
      else $error("frame end did not rewind position and start a job");

   a_status_ends_job: assert property (@(posedge clock) disable iff (reset)
      (drain_go && job_count_ff == '0) |=> (!job_active_ff && rsp_valid_ff
                                            && rsp_last_ff))
      else $error("status result did not close the job");

endmodule
